@@ design/row_transition_band_detector_defines.svh @@
// Assertion macros used by the row transition band detector top level.
`ifndef ROW_TRANSITION_BAND_DETECTOR_DEFINES_SVH
`define ROW_TRANSITION_BAND_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RTBD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/rtbd_pkg.sv @@
// Types and constants of the row transition band detector.
package rtbd_pkg;

   localparam int PIXEL_W  = 8;
   localparam int CHG_W    = 11;
   localparam int HEIGHT_W = 10;
   localparam int ROWF_W   = 10;
   localparam int TOTAL_W  = 10;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 11;
   localparam int RSP_DATA_W = 32;

   localparam logic [CHG_W-1:0]   CHG_MAX   = 11'd2047;
   localparam logic [TOTAL_W-1:0] BAND_MAX  = 10'd512;
   localparam logic [CHG_W-1:0]   THRESHOLD_RESET  = 11'd7;
   localparam logic [HEIGHT_W-1:0] MIN_HEIGHT_RESET = 10'd8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HEIGHT = 1'b1;

   // Result kinds.
   localparam logic KIND_BAND    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Output queue depth; an accepted word may push two results.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_LVL_W = 3;

   typedef struct packed {
      logic                kind;
      logic [ROWF_W-1:0]   band_start;
      logic [ROWF_W-1:0]   band_end;
      logic [TOTAL_W-1:0]  band_total;
      logic                last;
   } rsp_item_type;

   typedef struct packed {
      logic         valid0;
      logic         valid1;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

endpackage

@@ design/row_transition_band_detector.sv @@
// Top level of the row transition band detector.
//
//   channel   dir   handshake           payload
//   req_      in    tvalid/tready       tdata pixel, tlast row_end, tuser frame_end
//   rsp_      out   tvalid/tready       tdata band rows and total, tlast last, tuser kind
//   csr_      in    wr_en (no wait)     index, wdata
//
// One pixel word is taken per cycle; the band decision is made in the cycle the
// word is accepted and its results enter a four-entry result queue.
// The queue can absorb the two results of a frame-end word, so input is held
// back only while fewer than two queue entries are free.
// Results leave one per cycle; a stalled result side fills the queue and then stalls input.
// Reset is synchronous and clears the row, band and frame state and the queue.
module row_transition_band_detector #(
   parameter int MAX_ROWS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: pixel [7:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rtbd_pkg::PIXEL_W-1:0]        req_tdata,
   input  logic                                req_tlast,
   // req_tuser: frame_end [0]
   input  logic                                req_tuser,
   // rsp_tdata: band_start [9:0], band_end [19:10], band_total [29:20], zero [31:30]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rtbd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   // rsp_tuser: kind [0]
   output logic                                rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [rtbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rtbd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rtbd_pkg::*;

   logic [CHG_W-1:0]    threshold_ff;
   logic [HEIGHT_W-1:0] min_height_ff;
   logic                req_accept;
   logic                rsp_accept;
   rsp_push_type        push;
   rsp_item_type        head;
   logic                queue_room2;
   logic [RSP_LVL_W-1:0] queue_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         min_height_ff <= MIN_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata;
            CSR_MIN_HEIGHT: min_height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = queue_room2;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   rtbd_core #(
      .MAX_ROWS (MAX_ROWS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .pixel      (req_tdata),
      .row_end    (req_tlast),
      .frame_end  (req_tuser),
      .threshold  (threshold_ff),
      .min_height (min_height_ff),
      .push       (push)
   );

   rtbd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_accept),
      .head      (head),
      .not_empty (rsp_tvalid),
      .room2     (queue_room2),
      .level     (queue_level)
   );

   assign rsp_tdata = {2'b00, head.band_total, head.band_end, head.band_start};
   assign rsp_tlast = head.last;
   assign rsp_tuser = head.kind;

`include "row_transition_band_detector_defines.svh"

   `RTBD_ASSERT_NOW(a_queue_bound, 1'b1, queue_level <= RSP_LVL_W'(RSP_DEPTH), "result queue overflow")
   `RTBD_ASSERT_NEXT(a_frame_summary, req_accept && req_tuser, rsp_tvalid, "frame end gave no summary")
   `RTBD_ASSERT_NOW(a_summary_rows, rsp_tvalid && (rsp_tuser == KIND_SUMMARY), (rsp_tdata[19:0] == 20'd0) && rsp_tlast, "summary carries band rows or is not last")

endmodule

@@ design/rtbd_core.sv @@
// Per-row change counting and band open/close decisions.
module rtbd_core #(
   parameter int MAX_ROWS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [rtbd_pkg::PIXEL_W-1:0]    pixel,
   input  logic                            row_end,
   input  logic                            frame_end,
   input  logic [rtbd_pkg::CHG_W-1:0]      threshold,
   input  logic [rtbd_pkg::HEIGHT_W-1:0]   min_height,
   output rtbd_pkg::rsp_push_type          push
);
   import rtbd_pkg::*;

   localparam int RowW  = $clog2(MAX_ROWS);
   localparam int SpanW = (RowW > HEIGHT_W) ? RowW : HEIGHT_W;
   localparam logic [RowW-1:0] RowLast = RowW'(MAX_ROWS - 1);

   logic [PIXEL_W-1:0] prev_pixel_ff, prev_pixel_in;
   logic               has_pixel_ff, has_pixel_in;
   logic [CHG_W-1:0]   chg_count_ff, chg_count_in;
   logic [RowW-1:0]    row_ff, row_in;
   logic               open_ff, open_in;
   logic [RowW-1:0]    start_ff, start_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic [CHG_W-1:0]   chg_next;
   logic               row_done;
   logic               busy;
   logic [RowW-1:0]    span;
   logic               span_ok;
   logic               close;
   logic [RowW-1:0]    end_row;
   logic [TOTAL_W-1:0] total_next;
   rsp_item_type       report;
   rsp_item_type       summary;

   always_comb begin
      chg_next = chg_count_ff;
      if (has_pixel_ff && (pixel != prev_pixel_ff) && (chg_count_ff != CHG_MAX)) begin
         chg_next = chg_count_ff + 1'b1;
      end
      row_done = row_end || frame_end;
      busy     = chg_next >= threshold;
      span     = row_ff - start_ff;
      span_ok  = (row_ff >= start_ff) && (SpanW'(span) >= SpanW'(min_height));
      close    = row_done && open_ff && !busy && span_ok;
      // A band that closes on its own start row reports that row as its end.
      end_row  = (row_ff > start_ff) ? (row_ff - 1'b1) : start_ff;
      total_next = total_ff;
      if (close && (total_ff < BAND_MAX)) begin
         total_next = total_ff + 1'b1;
      end

      report.kind       = KIND_BAND;
      report.band_start = ROWF_W'(start_ff);
      report.band_end   = ROWF_W'(end_row);
      report.band_total = total_next;
      report.last       = !frame_end;

      summary.kind       = KIND_SUMMARY;
      summary.band_start = '0;
      summary.band_end   = '0;
      summary.band_total = total_next;
      summary.last       = 1'b1;

      push.valid0 = accept && (close || frame_end);
      push.valid1 = accept && close && frame_end;
      push.item0  = close ? report : summary;
      push.item1  = summary;
   end

   always_comb begin
      prev_pixel_in = prev_pixel_ff;
      has_pixel_in  = has_pixel_ff;
      chg_count_in  = chg_count_ff;
      row_in        = row_ff;
      open_in       = open_ff;
      start_in      = start_ff;
      total_in      = total_ff;
      if (accept) begin
         if (frame_end) begin
            // Frame end drops any open band and starts the next frame clean.
            prev_pixel_in = '0;
            has_pixel_in  = 1'b0;
            chg_count_in  = '0;
            row_in        = '0;
            open_in       = 1'b0;
            start_in      = '0;
            total_in      = '0;
         end else begin
            prev_pixel_in = pixel;
            has_pixel_in  = !row_done;
            chg_count_in  = row_done ? '0 : chg_next;
            total_in      = total_next;
            if (row_done) begin
               if (row_ff != RowLast) begin
                  row_in = row_ff + 1'b1;
               end
               if (!open_ff && busy) begin
                  open_in  = 1'b1;
                  start_in = row_ff;
               end else if (close) begin
                  open_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pixel_ff <= '0;
         has_pixel_ff  <= 1'b0;
         chg_count_ff  <= '0;
         row_ff        <= '0;
         open_ff       <= 1'b0;
         start_ff      <= '0;
         total_ff      <= '0;
      end else begin
         prev_pixel_ff <= prev_pixel_in;
         has_pixel_ff  <= has_pixel_in;
         chg_count_ff  <= chg_count_in;
         row_ff        <= row_in;
         open_ff       <= open_in;
         start_ff      <= start_in;
         total_ff      <= total_in;
      end
   end

endmodule

@@ design/rtbd_rsp_fifo.sv @@
// Result queue taking up to two results per cycle and giving one.
module rtbd_rsp_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  rtbd_pkg::rsp_push_type             push,
   input  logic                               pop,
   output rtbd_pkg::rsp_item_type             head,
   output logic                               not_empty,
   output logic                               room2,
   output logic [rtbd_pkg::RSP_LVL_W-1:0]     level
);
   import rtbd_pkg::*;

   rsp_item_type         items_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_LVL_W-1:0] level_ff, level_in;
   logic [RSP_LVL_W-1:0] push_n;
   logic                 pop_ok;

   always_comb begin
      pop_ok    = pop && (level_ff != '0);
      push_n    = RSP_LVL_W'(push.valid0) + RSP_LVL_W'(push.valid1);
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop_ok);
      level_in  = level_ff + push_n - RSP_LVL_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         items_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.valid1) begin
         items_ff[wr_ptr_ff + 1'b1] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head      = items_ff[rd_ptr_ff];
   assign not_empty = level_ff != '0;
   assign room2     = level_ff <= RSP_LVL_W'(RSP_DEPTH - 2);
   assign level     = level_ff;

endmodule

@@ bench/row_transition_band_detector_test.sv @@
// Self-checking testbench for the row transition band detector: streamed pixels, band reports.
module row_transition_band_detector_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rtbd_pkg::*;

   localparam int ROW_LIMIT     = 1024;
   localparam int RANDOM_WORDS  = 700;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
      logic               frame_end;
   } pixel_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Words waiting to be offered, and band reports and summaries still to come.
   pixel_word_type pixel_words[$];
   rsp_item_type   band_reports[$];
   pixel_word_type next_word;
   rsp_item_type   oldest_report;

   int queued_words  = 0;
   int error_count   = 0;
   int cycle_count   = 0;
   int req_idle_pct  = 30;
   int rsp_stall_pct = 30;
   bit pressure_on   = 1'b0;
   int hold_left     = 0;
   bit hold_used     = 1'b0;

   // Predictor copy of the registers and the row and band state.
   logic [CHG_W-1:0]    thresh_cfg     = THRESHOLD_RESET;
   logic [HEIGHT_W-1:0] height_cfg     = MIN_HEIGHT_RESET;
   logic [PIXEL_W-1:0]  last_pixel     = '0;
   logic                row_started    = 1'b0;
   logic [CHG_W-1:0]    row_changes    = '0;
   logic [ROWF_W-1:0]   cur_row        = '0;
   logic                in_band        = 1'b0;
   logic [ROWF_W-1:0]   band_first_row = '0;
   logic [TOTAL_W-1:0]  bands_found    = '0;

   row_transition_band_detector #(.MAX_ROWS(ROW_LIMIT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void track_band_rows(input logic [PIXEL_W-1:0] pix,
                                           input logic row_end, input logic frame_end);
      rsp_item_type caused[$];
      rsp_item_type rep;
      logic         busy;
      if (row_started && pix != last_pixel && row_changes != CHG_MAX) row_changes++;
      last_pixel  = pix;
      row_started = 1'b1;
      if (row_end || frame_end) begin
         busy = row_changes >= thresh_cfg;
         if (!in_band) begin
            if (busy) begin
               in_band        = 1'b1;
               band_first_row = cur_row;
            end
         end else if (!busy && cur_row >= band_first_row &&
                      ROWF_W'(cur_row - band_first_row) >= height_cfg) begin
            if (bands_found < BAND_MAX) bands_found++;
            rep.kind       = KIND_BAND;
            rep.band_start = band_first_row;
            // A band closing on its own start row reports that row as its end.
            rep.band_end   = (cur_row > band_first_row) ? cur_row - 1'b1 : band_first_row;
            rep.band_total = bands_found;
            rep.last       = 1'b0;
            caused.push_back(rep);
            in_band = 1'b0;
         end
         row_changes = '0;
         row_started = 1'b0;
         if (cur_row < ROW_LIMIT - 1) cur_row++;
      end
      if (frame_end) begin
         rep.kind       = KIND_SUMMARY;
         rep.band_start = '0;
         rep.band_end   = '0;
         rep.band_total = bands_found;
         rep.last       = 1'b0;
         caused.push_back(rep);
         // An open band is dropped at frame end.
         last_pixel     = '0;
         row_started    = 1'b0;
         row_changes    = '0;
         cur_row        = '0;
         in_band        = 1'b0;
         band_first_row = '0;
         bands_found    = '0;
      end
      foreach (caused[i]) begin
         if (i == caused.size() - 1) caused[i].last = 1'b1;
         band_reports.push_back(caused[i]);
      end
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Pixel word driver; the predictor runs on each accepted word.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) track_band_rows(req_tdata, req_tlast, req_tuser);
         if (!req_tvalid || req_tready) begin
            if (pixel_words.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               next_word = pixel_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_word.pixel;
               req_tlast  <= next_word.row_end;
               req_tuser  <= next_word.frame_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random stalls and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_used  <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (band_reports.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               oldest_report = band_reports.pop_front();
               check_field("kind", int'(oldest_report.kind), int'(rsp_tuser));
               check_field("band_start", int'(oldest_report.band_start),
                           int'(rsp_tdata[9:0]));
               check_field("band_end", int'(oldest_report.band_end), int'(rsp_tdata[19:10]));
               check_field("band_total", int'(oldest_report.band_total),
                           int'(rsp_tdata[29:20]));
               check_field("tdata padding", 0, int'(rsp_tdata[31:30]));
               check_field("last", int'(oldest_report.last), int'(rsp_tlast));
            end
         end
         if (pressure_on && !hold_used) begin
            hold_used  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void push_word(input logic [PIXEL_W-1:0] pix, input logic row_end,
                                     input logic frame_end);
      pixel_word_type w;
      w.pixel     = pix;
      w.row_end   = row_end;
      w.frame_end = frame_end;
      pixel_words.push_back(w);
      queued_words++;
   endfunction

   // One row with an exact number of pixel changes, placed at random.
   task automatic add_row(input int changes, input int extra, input bit row_mark,
                          input bit frame_mark);
      int                 width;
      int                 left;
      bit                 flip;
      logic [PIXEL_W-1:0] pix;
      width = changes + 1 + extra;
      left  = changes;
      pix   = PIXEL_W'($urandom_range(255));
      for (int i = 0; i < width; i++) begin
         if (i > 0) begin
            flip = (left == width - i) || (left > 0 && $urandom_range(1) == 1);
            if (flip) begin
               pix = pix ^ PIXEL_W'($urandom_range(1, 255));
               left--;
            end
         end
         push_word(pix, (i == width - 1) && row_mark, (i == width - 1) && frame_mark);
      end
   endtask

   // A frame of busy and quiet runs around the current threshold, so bands open and close.
   task automatic add_band_frame(input int rows);
      int thr;
      int run_left;
      bit busy;
      bit final_row;
      thr      = int'(thresh_cfg);
      run_left = 0;
      busy     = 1'($urandom_range(1));
      for (int r = 0; r < rows; r++) begin
         if (run_left == 0) begin
            busy     = !busy;
            run_left = $urandom_range(1, 5);
         end
         run_left--;
         final_row = (r == rows - 1);
         // The frame's last word may or may not carry its own row end.
         if (busy || thr == 0)
            add_row($urandom_range(thr, thr + 2), $urandom_range(2),
                    final_row ? 1'($urandom_range(1)) : 1'b1, final_row);
         else
            add_row($urandom_range(thr - 1), $urandom_range(2),
                    final_row ? 1'($urandom_range(1)) : 1'b1, final_row);
      end
   endtask

   task automatic add_noise_frame(input int words);
      for (int i = 0; i < words; i++)
         push_word(PIXEL_W'($urandom_range(255)), $urandom_range(5) == 0, i == words - 1);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_THRESHOLD) thresh_cfg = CHG_W'(value);
      else height_cfg = HEIGHT_W'(value);
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      do @(negedge clock); while (pixel_words.size() != 0 || req_tvalid);
      while (band_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int random_start;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a busy row opens a band that the frame end then drops.
      for (int i = 0; i < 8; i++) push_word(i[0] ? 8'd255 : 8'd0, i == 7, 1'b0);
      push_word(8'd128, 1'b0, 1'b1);
      wait_drained();

      // Bands closing after one row, one of them on a frame end without a row end.
      write_register(CSR_THRESHOLD, 1);
      write_register(CSR_MIN_HEIGHT, 1);
      push_word(8'd255, 1'b0, 1'b0);
      push_word(8'd0, 1'b1, 1'b0);
      push_word(8'd7, 1'b1, 1'b0);
      push_word(8'd3, 1'b0, 1'b0);
      push_word(8'd3, 1'b0, 1'b0);
      push_word(8'd200, 1'b1, 1'b0);
      push_word(8'd9, 1'b0, 1'b1);
      push_word(8'd0, 1'b1, 1'b0);
      push_word(8'd1, 1'b0, 1'b0);
      push_word(8'd2, 1'b1, 1'b1);
      wait_drained();

      // Past the last row index: band count saturates and a band closes on its start row.
      write_register(CSR_MIN_HEIGHT, 0);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      for (int r = 0; r < ROW_LIMIT + 6; r++) begin
         if (r[0]) add_row(0, 0, 1'b1, r == ROW_LIMIT + 5);
         else add_row(1, 0, 1'b1, 1'b0);
      end
      wait_drained();

      // A row long enough to saturate the change count at the top threshold.
      req_idle_pct  = 30;
      rsp_stall_pct = 30;
      write_register(CSR_THRESHOLD, 2047);
      add_row(2099, 0, 1'b1, 1'b0);
      add_row(0, 0, 1'b0, 1'b1);
      wait_drained();

      // Every row busy and the tallest height: bands open but never close.
      write_register(CSR_THRESHOLD, 0);
      write_register(CSR_MIN_HEIGHT, 1023);
      add_band_frame(8);
      add_band_frame(5);
      wait_drained();

      // Many short frames while the receiver holds off, so the input stalls.
      write_register(CSR_THRESHOLD, 1);
      write_register(CSR_MIN_HEIGHT, 0);
      req_idle_pct = 0;
      for (int i = 0; i < 40; i++) begin
         if (i % 8 == 0) add_band_frame(6);
         else push_word(PIXEL_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end
      pressure_on = 1'b1;
      wait_drained();
      pressure_on  = 1'b0;
      req_idle_pct = 30;

      random_start = queued_words;
      while (queued_words - random_start < RANDOM_WORDS) begin
         write_register(CSR_THRESHOLD, $urandom_range(8));
         write_register(CSR_MIN_HEIGHT, $urandom_range(5));
         repeat ($urandom_range(2, 4)) begin
            if ($urandom_range(9) < 8) add_band_frame($urandom_range(3, 14));
            else add_noise_frame($urandom_range(3, 40));
         end
         wait_drained();
      end

      if (band_reports.size() != 0) begin
         $display("%0t: %0d results missing, expected kind %0d total %0d, actual none",
                  $time, band_reports.size(), band_reports[0].kind, band_reports[0].band_total);
         error_count++;
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
